FILE: src/rtp_pkg.sv
// rtp_pkg: shared types, constants and helpers for the radix integer text parser
// no dependencies; used by rtp_step and radix_integer_text_parser
package rtp_pkg;

	localparam int ACC_W     = 64;
	localparam int EXC_W     = 12;
	localparam int CHAR_W    = 8;
	localparam int RADIX_W   = 6;
	localparam int DIGIT_W   = 6;
	localparam int RADIX_MAX = 36;

	localparam logic [ACC_W-1:0] ACC_TOP = '1;
	localparam logic [EXC_W-1:0] EXC_MAX = '1;

	localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
	localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
	localparam logic [RADIX_W-1:0] RADIX_TOP  = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_LOW  = 6'd2;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] ALPHA_OFS = 8'd10;

	// largest new accumulator value (acc * radix + digit) that is still stored, per radix
	localparam logic [ACC_W-1:0] LIMIT [0:RADIX_MAX] = '{
		'0, '0,
		ACC_TOP/2-2,   ACC_TOP/3-3,   ACC_TOP/4-4,   ACC_TOP/5-5,   ACC_TOP/6-6,
		ACC_TOP/7-7,   ACC_TOP/8-8,   ACC_TOP/9-9,   ACC_TOP/10-10, ACC_TOP/11-11,
		ACC_TOP/12-12, ACC_TOP/13-13, ACC_TOP/14-14, ACC_TOP/15-15, ACC_TOP/16-16,
		ACC_TOP/17-17, ACC_TOP/18-18, ACC_TOP/19-19, ACC_TOP/20-20, ACC_TOP/21-21,
		ACC_TOP/22-22, ACC_TOP/23-23, ACC_TOP/24-24, ACC_TOP/25-25, ACC_TOP/26-26,
		ACC_TOP/27-27, ACC_TOP/28-28, ACC_TOP/29-29, ACC_TOP/30-30, ACC_TOP/31-31,
		ACC_TOP/32-32, ACC_TOP/33-33, ACC_TOP/34-34, ACC_TOP/35-35, ACC_TOP/36-36
	};

	typedef enum logic [4:0] {
		PH_SIGN   = 5'b00001,
		PH_FIRST  = 5'b00010,
		PH_ZERO   = 5'b00100,
		PH_DIGITS = 5'b01000,
		PH_STOP   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              is_last;
	} in_item_t;

	typedef struct packed {
		logic [ACC_W-1:0] magnitude;
		logic [EXC_W-1:0] excess_digits;
		logic             negative;
		logic             not_a_number;
	} out_item_t;

	typedef struct packed {
		phase_t             phase;
		logic [ACC_W-1:0]   acc;
		logic [EXC_W-1:0]   excess;
		logic               neg;
		logic [RADIX_W-1:0] radix;
		logic               consumed;
	} parse_state_t;

	localparam parse_state_t STATE_INIT = '{
		phase:    PH_SIGN,
		acc:      '0,
		excess:   '0,
		neg:      1'b0,
		radix:    RADIX_AUTO,
		consumed: 1'b0
	};

	function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
		return (r == RADIX_AUTO) || ((r >= RADIX_LOW) && (r <= RADIX_TOP));
	endfunction

endpackage

FILE: src/rtp_step.sv
// rtp_step: one character of parsing, sign/prefix decode and multiply-add accumulate
// depends on rtp_pkg
module rtp_step (
	input  rtp_pkg::parse_state_t    cur,
	input  rtp_pkg::in_item_t        item,
	input  logic [rtp_pkg::RADIX_W-1:0] cfg_radix,
	output rtp_pkg::parse_state_t    nxt_state,
	output rtp_pkg::out_item_t       res
);

	rtp_pkg::parse_state_t            nxt;
	logic [rtp_pkg::RADIX_W-1:0]      r;
	logic                             go_first;
	logic                             take;
	logic [rtp_pkg::CHAR_W-1:0]       c;
	logic [rtp_pkg::CHAR_W-1:0]       dv;
	logic                             is_dig;
	logic [rtp_pkg::DIGIT_W-1:0]      d;
	logic [rtp_pkg::ACC_W-1:0]        lim;
	logic [rtp_pkg::ACC_W+rtp_pkg::RADIX_W-1:0] prod;
	logic [rtp_pkg::ACC_W+rtp_pkg::RADIX_W-1:0] t;
	logic                             bad;
	logic                             nan;

	assign c = item.char_code;

	// digit decode
	always_comb begin
		is_dig = 1'b1;
		dv     = '0;
		if ((c >= rtp_pkg::CH_ZERO) && (c <= rtp_pkg::CH_NINE)) begin
			dv = c - rtp_pkg::CH_ZERO;
		end else if ((c >= rtp_pkg::CH_LA) && (c <= rtp_pkg::CH_LZ)) begin
			dv = c - rtp_pkg::CH_LA + rtp_pkg::ALPHA_OFS;
		end else if ((c >= rtp_pkg::CH_UA) && (c <= rtp_pkg::CH_UZ)) begin
			dv = c - rtp_pkg::CH_UA + rtp_pkg::ALPHA_OFS;
		end else begin
			is_dig = 1'b0;
		end
		d = dv[rtp_pkg::DIGIT_W-1:0];
	end

	always_comb begin
		nxt      = cur;
		r        = cur.radix;
		go_first = 1'b0;
		take     = 1'b0;
		unique case (cur.phase)
			rtp_pkg::PH_SIGN: begin
				r = cfg_radix;
				if (!rtp_pkg::radix_ok(cfg_radix)) begin
					nxt.phase = rtp_pkg::PH_STOP;
				end else if (c == rtp_pkg::CH_MINUS) begin
					nxt.neg   = 1'b1;
					nxt.phase = rtp_pkg::PH_FIRST;
				end else if (c == rtp_pkg::CH_PLUS) begin
					nxt.phase = rtp_pkg::PH_FIRST;
				end else begin
					go_first = 1'b1;
				end
			end
			rtp_pkg::PH_FIRST: begin
				go_first = 1'b1;
			end
			rtp_pkg::PH_ZERO: begin
				if (((c == rtp_pkg::CH_LX) || (c == rtp_pkg::CH_UX)) && !item.is_last) begin
					r         = rtp_pkg::RADIX_HEX;
					nxt.phase = rtp_pkg::PH_DIGITS;
				end else begin
					r    = rtp_pkg::RADIX_DEC;
					take = 1'b1;
				end
			end
			rtp_pkg::PH_DIGITS: begin
				take = 1'b1;
			end
			rtp_pkg::PH_STOP: begin
			end
			default: begin
			end
		endcase

		if (go_first) begin
			if ((r == rtp_pkg::RADIX_AUTO) && (c == rtp_pkg::CH_ZERO)) begin
				nxt.consumed = 1'b1;
				nxt.phase    = rtp_pkg::PH_ZERO;
			end else begin
				if (r == rtp_pkg::RADIX_AUTO) begin
					r = rtp_pkg::RADIX_DEC;
				end
				take = 1'b1;
			end
		end
		nxt.radix = r;

		lim  = (r <= rtp_pkg::RADIX_TOP) ? rtp_pkg::LIMIT[r] : '0;
		prod = cur.acc * r;
		t    = prod + (rtp_pkg::ACC_W+rtp_pkg::RADIX_W)'(d);

		if (take) begin
			if ((r < rtp_pkg::RADIX_LOW) || !is_dig || (d >= r)) begin
				nxt.phase = rtp_pkg::PH_STOP;
			end else begin
				nxt.phase    = rtp_pkg::PH_DIGITS;
				nxt.consumed = 1'b1;
				if ((cur.excess != '0) ||
				    (t > (rtp_pkg::ACC_W+rtp_pkg::RADIX_W)'(lim))) begin
					if (cur.excess != rtp_pkg::EXC_MAX) begin
						nxt.excess = cur.excess + rtp_pkg::EXC_W'(1);
					end
				end else begin
					nxt.acc = t[rtp_pkg::ACC_W-1:0];
				end
			end
		end

		bad = !rtp_pkg::radix_ok(nxt.radix);
		nan = bad || !nxt.consumed;
		res.magnitude     = nan ? '0 : nxt.acc;
		res.excess_digits = nan ? '0 : nxt.excess;
		res.negative      = bad ? 1'b0 : nxt.neg;
		res.not_a_number  = nan;

		nxt_state = item.is_last ? rtp_pkg::STATE_INIT : nxt;
	end

endmodule

FILE: src/radix_integer_text_parser.sv
// radix_integer_text_parser: top level, input register, parse state, result register
// result: written to the result register when its last character advances out of the input register
// throughput: one character per cycle, except that a last character waits while the held result is stalled
// reset: asynchronous, clears parse state, the radix register (auto) and all valid flags
// depends on rtp_pkg and rtp_step
module radix_integer_text_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  rtp_pkg::in_item_t            item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output rtp_pkg::out_item_t           result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rtp_pkg::RADIX_W-1:0]  cfg_data
);

	rtp_pkg::in_item_t            item_s1;
	logic                         valid_s1;
	rtp_pkg::parse_state_t        state_q;
	rtp_pkg::parse_state_t        state_next;
	rtp_pkg::out_item_t           res_next;
	rtp_pkg::out_item_t           result_q;
	logic                         result_valid_q;
	logic [rtp_pkg::RADIX_W-1:0]  radix_q;
	logic                         out_free;
	logic                         advance;

	assign cfg_ready    = 1'b1;
	assign out_free     = !result_valid_q || !result_stall;
	assign advance      = valid_s1 && (!item_s1.is_last || out_free);
	assign item_stall   = valid_s1 && !advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rtp_pkg::RADIX_AUTO;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	rtp_step u_step (
		.cur       (state_q),
		.item      (item_s1),
		.cfg_radix (radix_q),
		.nxt_state (state_next),
		.res       (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtp_pkg::STATE_INIT;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.is_last) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.is_last) begin
			result_q <= res_next;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.is_last |=> state_q.phase == rtp_pkg::PH_SIGN && !state_q.consumed)
		else $error("parse state not cleared after last character");

	a_nan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.not_a_number |->
			result_q.magnitude == '0 && result_q.excess_digits == '0)
		else $error("nan result carries a value");

	a_excess_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.excess != '0 |->
			state_q.phase == rtp_pkg::PH_DIGITS || state_q.phase == rtp_pkg::PH_STOP)
		else $error("excess count outside digit phase");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && item_s1.is_last && result_valid_q && result_stall)
		else $error("input stalled without a blocked result");

endmodule
